>>> rtl/clock_button_mode_controller_assert.svh
// assertion macros for the clock button mode controller
// CBMC_ASSERT checks a property every clock edge outside reset
// CBMC_ASSERT_NEXT checks that an antecedent implies a consequent in the next cycle
`ifndef CLOCK_BUTTON_MODE_CONTROLLER_ASSERT_SVH
`define CLOCK_BUTTON_MODE_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

`define CBMC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define CBMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CBMC_ASSERT(lbl, clk, rst, prop, msg)

`define CBMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/cbmc_pkg.sv
`timescale 1ns / 1ps

package cbmc_pkg;

   // event codes
   localparam logic [1:0] ACT_POLL  = 2'd0;
   localparam logic [1:0] ACT_TIME  = 2'd1;
   localparam logic [1:0] ACT_BLINK = 2'd2;

   // limits and reset values
   localparam logic [7:0] LONG_PRESS_RESET = 8'd40;
   localparam logic [7:0] HOLD_MAX         = 8'd255;
   localparam logic [4:0] HOURS_PER_DAY    = 5'd24;
   localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
   localparam logic [1:0] CHANGES_PER_PRESS = 2'd2;

   // one input beat
   typedef struct packed {
      logic [1:0] action;
      logic       touch_level;
      logic       left_level;
      logic       right_level;
      logic [4:0] rtc_hours;
      logic [5:0] rtc_minutes;
   } req_type;

   // one result beat
   typedef struct packed {
      logic [1:0] hour_tens;
      logic [3:0] hour_units;
      logic [2:0] minute_tens;
      logic [3:0] minute_units;
      logic       dot_lit;
      logic       write_hours;
      logic       write_minutes;
      logic       save_time;
      logic [1:0] led_toggles;
      logic       next_eye_color;
      logic       eye_blink;
      logic       eyes_on;
   } rsp_type;

   // tens digit of a value below 64, by reciprocal multiply
   function automatic logic [2:0] tens_of(input logic [5:0] value);
      logic [9:0] prod;
      prod = 10'(value) * 10'd13;
      return prod[9:7];
   endfunction

   // units digit of a value below 64
   function automatic logic [3:0] units_of(input logic [5:0] value);
      logic [5:0] tens_x10;
      logic [5:0] diff;
      tens_x10 = 6'(tens_of(value)) * 6'd10;
      diff = value - tens_x10;
      return diff[3:0];
   endfunction

endpackage

>>> rtl/cbmc_if.sv
`timescale 1ns / 1ps

// event channel
interface cbmc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic       touch_level;
   logic       left_level;
   logic       right_level;
   logic [4:0] rtc_hours;
   logic [5:0] rtc_minutes;

   modport source (
      output valid, action, touch_level, left_level, right_level, rtc_hours, rtc_minutes,
      input  ready
   );
   modport sink (
      input  valid, action, touch_level, left_level, right_level, rtc_hours, rtc_minutes,
      output ready
   );
endinterface

// display and pulse channel
interface cbmc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] hour_tens;
   logic [3:0] hour_units;
   logic [2:0] minute_tens;
   logic [3:0] minute_units;
   logic       dot_lit;
   logic       write_hours;
   logic       write_minutes;
   logic       save_time;
   logic [1:0] led_toggles;
   logic       next_eye_color;
   logic       eye_blink;
   logic       eyes_on;

   modport source (
      output valid, hour_tens, hour_units, minute_tens, minute_units, dot_lit,
             write_hours, write_minutes, save_time, led_toggles, next_eye_color,
             eye_blink, eyes_on,
      input  ready
   );
   modport sink (
      input  valid, hour_tens, hour_units, minute_tens, minute_units, dot_lit,
             write_hours, write_minutes, save_time, led_toggles, next_eye_color,
             eye_blink, eyes_on,
      output ready
   );
endinterface

>>> rtl/clock_button_mode_controller.sv
`timescale 1ns / 1ps

// Mode controller for a desk clock. Each req beat is one event: a button poll
// (touch, left, right levels), a time update (clock hours and minutes) or a
// blink tick. Every event gives exactly one rsp beat carrying the digits of
// the stored time and the pulses it caused. One beat is accepted per cycle
// while the output is not stalled; a beat passes an input register and then
// a result register before its result can be taken. Under rsp back-pressure
// the input register still takes one more beat, then both hold. csr_wr_data
// sets the number of polls with left held before idle and time setup swap
// (reset 40); write it only while no beat is in flight. No clearing pass
// after reset.

`include "clock_button_mode_controller_assert.svh"

module clock_button_mode_controller (
   input  logic       clock,
   input  logic       reset,
   cbmc_req_if.sink   req_bus,
   cbmc_rsp_if.source rsp_bus,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   // configuration
   logic [7:0] long_press_polls_ff;

   // pipeline registers
   logic                  s1_valid_ff, s1_valid_in;
   cbmc_pkg::req_type     s1_item_ff,  s1_item_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cbmc_pkg::rsp_type     rsp_ff,      rsp_in;

   // controller state
   logic       setup_mode_ff,    setup_mode_in;
   logic       dot_phase_ff,     dot_phase_in;
   logic       touch_prev_ff,    touch_prev_in;
   logic       left_prev_ff,     left_prev_in;
   logic       right_prev_ff,    right_prev_in;
   logic [1:0] touch_changes_ff, touch_changes_in;
   logic [1:0] left_changes_ff,  left_changes_in;
   logic [1:0] right_changes_ff, right_changes_in;
   logic [7:0] hold_count_ff,    hold_count_in;
   logic [4:0] hours_value_ff,   hours_value_in;
   logic [5:0] minutes_value_ff, minutes_value_in;

   logic req_accept;
   logic out_free;
   logic step_fire;

   // per-step scratch
   logic [1:0] touch_cnt, left_cnt, right_cnt;
   logic       touch_fire, left_fire, right_fire;
   logic [7:0] hold_mid;
   logic [4:0] hour_step;
   logic [5:0] minute_step;

   // handshake
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign step_fire  = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || out_free;
   assign req_accept = req_bus.valid && req_bus.ready;

   // input register
   always_comb begin
      s1_item_in.action      = req_bus.action;
      s1_item_in.touch_level = req_bus.touch_level;
      s1_item_in.left_level  = req_bus.left_level;
      s1_item_in.right_level = req_bus.right_level;
      s1_item_in.rtc_hours   = req_bus.rtc_hours;
      s1_item_in.rtc_minutes = req_bus.rtc_minutes;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (step_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // result valid
   always_comb begin
      if (step_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // event step
   always_comb begin
      setup_mode_in    = setup_mode_ff;
      dot_phase_in     = dot_phase_ff;
      touch_prev_in    = touch_prev_ff;
      left_prev_in     = left_prev_ff;
      right_prev_in    = right_prev_ff;
      touch_changes_in = touch_changes_ff;
      left_changes_in  = left_changes_ff;
      right_changes_in = right_changes_ff;
      hold_count_in    = hold_count_ff;
      hours_value_in   = hours_value_ff;
      minutes_value_in = minutes_value_ff;
      rsp_in           = '0;

      // change counters, a press-release pair fires
      touch_cnt = (s1_item_ff.touch_level != touch_prev_ff) ? touch_changes_ff + 2'd1
                                                            : touch_changes_ff;
      left_cnt  = (s1_item_ff.left_level != left_prev_ff)   ? left_changes_ff + 2'd1
                                                            : left_changes_ff;
      right_cnt = (s1_item_ff.right_level != right_prev_ff) ? right_changes_ff + 2'd1
                                                            : right_changes_ff;
      touch_fire = (touch_cnt == cbmc_pkg::CHANGES_PER_PRESS);
      left_fire  = (left_cnt == cbmc_pkg::CHANGES_PER_PRESS);
      right_fire = (right_cnt == cbmc_pkg::CHANGES_PER_PRESS);
      hold_mid   = left_fire ? 8'd0 : hold_count_ff;

      // wrapped setup steps
      hour_step   = (hours_value_ff + 5'd1 >= cbmc_pkg::HOURS_PER_DAY) ? 5'd0
                                                                       : hours_value_ff + 5'd1;
      minute_step = (minutes_value_ff + 6'd1 >= cbmc_pkg::MINUTES_PER_HOUR) ? 6'd0
                                                                : minutes_value_ff + 6'd1;

      unique case (s1_item_ff.action)
         cbmc_pkg::ACT_POLL: begin
            touch_prev_in    = s1_item_ff.touch_level;
            left_prev_in     = s1_item_ff.left_level;
            right_prev_in    = s1_item_ff.right_level;
            touch_changes_in = touch_fire ? 2'd0 : touch_cnt;
            left_changes_in  = left_fire  ? 2'd0 : left_cnt;
            right_changes_in = right_fire ? 2'd0 : right_cnt;
            rsp_in.next_eye_color = touch_fire;

            // right press: hand led or minute step
            if (right_fire) begin
               if (!setup_mode_ff) begin
                  rsp_in.led_toggles[1] = 1'b1;
               end else begin
                  minutes_value_in     = minute_step;
                  rsp_in.write_minutes = 1'b1;
                  rsp_in.save_time     = 1'b1;
               end
            end

            // left short press: backlight or hour step
            if (left_fire && (hold_count_ff < long_press_polls_ff)) begin
               if (!setup_mode_ff) begin
                  rsp_in.led_toggles[0] = 1'b1;
               end else begin
                  hours_value_in     = hour_step;
                  rsp_in.write_hours = 1'b1;
                  rsp_in.save_time   = 1'b1;
               end
            end

            // long press count and mode swap
            hold_count_in = hold_mid;
            if (s1_item_ff.left_level && (hold_mid != cbmc_pkg::HOLD_MAX)) begin
               hold_count_in = hold_mid + 8'd1;
               if (hold_mid + 8'd1 == long_press_polls_ff) begin
                  setup_mode_in  = !setup_mode_ff;
                  rsp_in.eyes_on = setup_mode_ff;
               end
            end
         end
         cbmc_pkg::ACT_TIME: begin
            if (!setup_mode_ff) begin
               hours_value_in       = s1_item_ff.rtc_hours;
               minutes_value_in     = s1_item_ff.rtc_minutes;
               rsp_in.dot_lit       = dot_phase_ff;
               rsp_in.write_hours   = 1'b1;
               rsp_in.write_minutes = 1'b1;
               dot_phase_in         = !dot_phase_ff;
            end
         end
         cbmc_pkg::ACT_BLINK: begin
            rsp_in.eye_blink = setup_mode_ff;
         end
         default: begin
         end
      endcase

      // digits of the stored time
      rsp_in.hour_tens    = 2'(cbmc_pkg::tens_of({1'b0, hours_value_in}));
      rsp_in.hour_units   = cbmc_pkg::units_of({1'b0, hours_value_in});
      rsp_in.minute_tens  = cbmc_pkg::tens_of(minutes_value_in);
      rsp_in.minute_units = cbmc_pkg::units_of(minutes_value_in);
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_polls_ff <= cbmc_pkg::LONG_PRESS_RESET;
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         setup_mode_ff       <= 1'b0;
         dot_phase_ff        <= 1'b0;
         touch_prev_ff       <= 1'b0;
         left_prev_ff        <= 1'b0;
         right_prev_ff       <= 1'b0;
         touch_changes_ff    <= 2'd0;
         left_changes_ff     <= 2'd0;
         right_changes_ff    <= 2'd0;
         hold_count_ff       <= 8'd0;
         hours_value_ff      <= 5'd0;
         minutes_value_ff    <= 6'd0;
      end else begin
         if (csr_wr_en) begin
            long_press_polls_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_fire) begin
            setup_mode_ff    <= setup_mode_in;
            dot_phase_ff     <= dot_phase_in;
            touch_prev_ff    <= touch_prev_in;
            left_prev_ff     <= left_prev_in;
            right_prev_ff    <= right_prev_in;
            touch_changes_ff <= touch_changes_in;
            left_changes_ff  <= left_changes_in;
            right_changes_ff <= right_changes_in;
            hold_count_ff    <= hold_count_in;
            hours_value_ff   <= hours_value_in;
            minutes_value_ff <= minutes_value_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= s1_item_in;
      end
      if (step_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // result port
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.hour_tens      = rsp_ff.hour_tens;
   assign rsp_bus.hour_units     = rsp_ff.hour_units;
   assign rsp_bus.minute_tens    = rsp_ff.minute_tens;
   assign rsp_bus.minute_units   = rsp_ff.minute_units;
   assign rsp_bus.dot_lit        = rsp_ff.dot_lit;
   assign rsp_bus.write_hours    = rsp_ff.write_hours;
   assign rsp_bus.write_minutes  = rsp_ff.write_minutes;
   assign rsp_bus.save_time      = rsp_ff.save_time;
   assign rsp_bus.led_toggles    = rsp_ff.led_toggles;
   assign rsp_bus.next_eye_color = rsp_ff.next_eye_color;
   assign rsp_bus.eye_blink      = rsp_ff.eye_blink;
   assign rsp_bus.eyes_on        = rsp_ff.eyes_on;

   // checks
   `CBMC_ASSERT(a_changes_below_pair, clock, reset, (touch_changes_ff != 2'd3) && (left_changes_ff != 2'd3) && (right_changes_ff != 2'd3), "change counter passed a full press")
   `CBMC_ASSERT(a_swap_at_threshold, clock, reset, !(step_fire && (setup_mode_in != setup_mode_ff)) || (hold_count_in == long_press_polls_ff), "mode swapped away from the long press threshold")
   `CBMC_ASSERT(a_dot_with_hours, clock, reset, !(rsp_valid_ff && rsp_ff.dot_lit) || rsp_ff.write_hours, "dot shown without an hour write")
   `CBMC_ASSERT_NEXT(a_eyes_on_leaves_setup, clock, reset, step_fire && rsp_in.eyes_on, !setup_mode_ff, "eyes on without leaving setup")
   `CBMC_ASSERT(a_save_only_in_setup, clock, reset, !(step_fire && rsp_in.save_time) || setup_mode_ff, "save requested outside setup")

endmodule
